>>> sv/pemt_pkg.sv
// Shared types and codes for the process ID event mask table.
// Used by pemt_cell and pid_event_mask_table; depends on nothing else.
package pemt_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic active;
        logic hit;
        logic free_seen;
    } flags_t;

    // Update command broadcast to every cell at the end of a search.
    typedef struct packed {
        logic       commit;
        logic [1:0] op;
        logic       hit;
    } cmd_t;

endpackage

>>> sv/pemt_cell.sv
// One table entry of the process ID event mask table, linked into the search chain.
// Depends on pemt_pkg for the token and command types and the operation codes.
module pemt_cell #(
    parameter int KEY_BITS  = 22,
    parameter int MASK_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pemt_pkg::flags_t      chain_in,
    input  logic [MASK_BITS-1:0]  chain_mask_in,
    output pemt_pkg::flags_t      chain_out,
    output logic [MASK_BITS-1:0]  chain_mask_out,
    input  pemt_pkg::cmd_t        cmd,
    input  logic [KEY_BITS-1:0]   cmd_key,
    input  logic [MASK_BITS-1:0]  cmd_evs
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    logic [MASK_BITS-1:0] mask_reg;
    logic [MASK_BITS-1:0] mask_next;
    logic                 mark_hit_reg;
    logic                 mark_free_reg;
    pemt_pkg::flags_t     flags_reg;
    pemt_pkg::flags_t     flags_next;
    logic [MASK_BITS-1:0] chain_mask_reg;
    logic                 hit_here;
    logic                 free_here;

    assign hit_here  = chain_in.active & valid_reg & (key_reg == cmd_key);
    assign free_here = chain_in.active & ~valid_reg & ~chain_in.free_seen;

    always_comb
    begin
        flags_next.active    = chain_in.active;
        flags_next.hit       = chain_in.hit | hit_here;
        flags_next.free_seen = chain_in.free_seen | free_here;
    end

    always_comb
    begin
        logic [MASK_BITS-1:0] cleared;
        cleared    = mask_reg & ~cmd_evs;
        valid_next = valid_reg;
        key_next   = key_reg;
        mask_next  = mask_reg;
        if (cmd.commit)
        begin
            unique case (cmd.op)
                pemt_pkg::OP_LOOKUP:
                begin
                end
                pemt_pkg::OP_ADD:
                begin
                    if (mark_hit_reg)
                    begin
                        mask_next = mask_reg | cmd_evs;
                    end
                    else if (!cmd.hit && mark_free_reg)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd_key;
                        mask_next  = cmd_evs;
                    end
                end
                pemt_pkg::OP_REMOVE:
                begin
                    if (mark_hit_reg)
                    begin
                        mask_next = cleared;
                        if (cleared == '0)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                end
                pemt_pkg::OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            mark_hit_reg  <= 1'b0;
            mark_free_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
            if (chain_in.active)
            begin
                mark_hit_reg  <= hit_here;
                mark_free_reg <= free_here;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        mask_reg       <= mask_next;
        chain_mask_reg <= hit_here ? mask_reg : chain_mask_in;
    end

    assign chain_out      = flags_reg;
    assign chain_mask_out = chain_mask_reg;

`ifndef SYNTHESIS
    // A slot is either the hit or the first free slot of a search, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mark_hit_reg && mark_free_reg))
        else $error("pemt_cell: slot marked as both hit and free");
`endif

endmodule

>>> sv/pid_event_mask_table.sv
// Top level of the process ID event mask table: item handshake, search chain, result buffer.
// Depends on pemt_pkg and pemt_cell.
//
// Usage: the input channel (in_valid, in_stall, operation, process_id, event_bits)
// carries one item per operation: lookup, add events, remove events or clear all.
// The output channel (out_valid, out_stall, mask_out, status) returns exactly one
// item per input item, in order. An item is taken at a clock edge where valid is
// high and stall is low.
// Each slot of the table is a cell in a chain. An accepted item launches a search
// token that moves one cell per cycle; every cell compares its stored key and notes
// whether it is the first free slot. When the token leaves the last cell, the result
// is formed and one update command is broadcast to all cells in the same edge.
// The result is registered in the output register (or the skid register) at the end
// of the search. Only one item is in flight at a time: in_stall stays high until the
// token has walked through the whole chain.
// Reset empties the table (all valid bits cleared) and drops any pending result.
// When the receiver stalls, a finished result waits in the output register and the
// next item is still accepted; a second finished result goes to a skid register, and
// in_stall stays high while that skid register is full.
module pid_event_mask_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 22,
    parameter int MASK_BITS     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [KEY_BITS-1:0]  process_id,
    input  logic [MASK_BITS-1:0] event_bits,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MASK_BITS-1:0] mask_out,
    output logic [1:0]           status
);

    // Control state.
    logic busy_reg;
    logic busy_next;
    logic start_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;

    // Held operands of the item in flight.
    logic [1:0]           op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [MASK_BITS-1:0] evs_reg;

    // Result buffers.
    logic [MASK_BITS-1:0] mask_out_reg;
    logic [MASK_BITS-1:0] mask_out_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [MASK_BITS-1:0] skid_mask_reg;
    logic [MASK_BITS-1:0] skid_mask_next;
    logic [1:0]           skid_status_reg;
    logic [1:0]           skid_status_next;

    // Search chain.
    pemt_pkg::flags_t     flags_chain [TABLE_ENTRIES+1];
    logic [MASK_BITS-1:0] mask_chain  [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0] active_vec;
    pemt_pkg::flags_t     chain_end;
    pemt_pkg::cmd_t       cmd;

    logic                 in_take;
    logic                 out_take;
    logic                 done;
    logic [MASK_BITS-1:0] res_mask;
    logic [1:0]           res_status;

    assign in_stall = busy_reg | skid_valid_reg;
    assign in_take  = in_valid & ~in_stall;
    assign out_take = out_valid_reg & ~out_stall;

    // The token enters the first cell through start_reg, in the cycle after the item is accepted.
    assign flags_chain[0] = '{active: start_reg, hit: 1'b0, free_seen: 1'b0};
    assign mask_chain[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            pemt_cell #(
                .KEY_BITS  (KEY_BITS),
                .MASK_BITS (MASK_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .chain_in       (flags_chain[gi]),
                .chain_mask_in  (mask_chain[gi]),
                .chain_out      (flags_chain[gi+1]),
                .chain_mask_out (mask_chain[gi+1]),
                .cmd            (cmd),
                .cmd_key        (key_reg),
                .cmd_evs        (evs_reg)
            );
        end
        for (gi = 0; gi <= TABLE_ENTRIES; gi++)
        begin : g_active
            assign active_vec[gi] = flags_chain[gi].active;
        end
    endgenerate

    assign chain_end = flags_chain[TABLE_ENTRIES];
    assign done      = chain_end.active;

    // The update command goes out in the same cycle the token leaves the chain.
    assign cmd = '{commit: done, op: op_reg, hit: chain_end.hit};

    // Result of the operation, from the search outcome and the held operands.
    always_comb
    begin
        res_mask   = '0;
        res_status = pemt_pkg::ST_OK;
        unique case (op_reg)
            pemt_pkg::OP_LOOKUP:
            begin
                if (chain_end.hit)
                begin
                    res_mask = mask_chain[TABLE_ENTRIES];
                end
            end
            pemt_pkg::OP_ADD:
            begin
                if (chain_end.hit)
                begin
                    res_mask = mask_chain[TABLE_ENTRIES] | evs_reg;
                end
                else if (chain_end.free_seen)
                begin
                    res_mask = evs_reg;
                end
                else
                begin
                    res_status = pemt_pkg::ST_FULL;
                end
            end
            pemt_pkg::OP_REMOVE:
            begin
                if (chain_end.hit)
                begin
                    res_mask = mask_chain[TABLE_ENTRIES] & ~evs_reg;
                end
                else
                begin
                    res_status = pemt_pkg::ST_NOT_FOUND;
                end
            end
            pemt_pkg::OP_CLEAR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register with a one-entry skid behind it. The skid register is
    // always empty when a search finishes, since no item is taken while it is full.
    always_comb
    begin
        busy_next        = busy_reg;
        out_valid_next   = out_valid_reg;
        skid_valid_next  = skid_valid_reg;
        mask_out_next    = mask_out_reg;
        status_next      = status_reg;
        skid_mask_next   = skid_mask_reg;
        skid_status_next = skid_status_reg;
        if (in_take)
        begin
            busy_next = 1'b1;
        end
        if (done)
        begin
            busy_next = 1'b0;
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                mask_out_next  = res_mask;
                status_next    = res_status;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_mask_next   = res_mask;
                skid_status_next = res_status;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_next = 1'b0;
                mask_out_next   = skid_mask_reg;
                status_next     = skid_status_reg;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start_reg      <= in_take;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            key_reg <= process_id;
            evs_reg <= event_bits;
        end
        mask_out_reg    <= mask_out_next;
        status_reg      <= status_next;
        skid_mask_reg   <= skid_mask_next;
        skid_status_reg <= skid_status_next;
    end

    assign out_valid = out_valid_reg;
    assign mask_out  = mask_out_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // At most one search token is in the chain at any time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_vec) <= 1)
        else $error("pid_event_mask_table: more than one token in the chain");

    // A token only leaves the chain while an item is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("pid_event_mask_table: search finished with no item in flight");

    // The skid register is only used behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("pid_event_mask_table: skid full while output register empty");

    // A new item is taken only when no token is in the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (active_vec == '0))
        else $error("pid_event_mask_table: item taken during a search");
`endif

endmodule
